// ----- rtl/core/iss_pkg.sv -----
// ----------------------------------------------------------------------------
// iss_pkg
// Types and constants shared by the indexed sequence store: operation and
// status codes, transfer payloads and controller commands.
// ----------------------------------------------------------------------------
package iss_pkg;

  localparam int unsigned Depth      = 16;
  localparam int unsigned DataWidth  = 32;
  localparam int unsigned PosWidth   = 4;
  localparam int unsigned CountWidth = $clog2(Depth + 1);
  localparam int unsigned IdxWidth   = $clog2(Depth);

  typedef enum logic [2:0] {
    OP_PUSH_BACK  = 3'd0,
    OP_PUSH_FRONT = 3'd1,
    OP_INSERT_AT  = 3'd2,
    OP_DELETE_AT  = 3'd3,
    OP_READ_AT    = 3'd4,
    OP_POP_BACK   = 3'd5,
    OP_POP_FRONT  = 3'd6,
    OP_CLEAR      = 3'd7
  } op_e;

  typedef enum logic [1:0] {
    STAT_DONE  = 2'd0,
    STAT_FULL  = 2'd1,
    STAT_RANGE = 2'd2
  } stat_e;

  typedef struct packed {
    op_e                   operation;
    logic [PosWidth-1:0]   position;
    logic [DataWidth-1:0]  value;
  } in_item_t;

  typedef struct packed {
    logic [DataWidth-1:0]  read_value;
    logic [CountWidth-1:0] count;
    stat_e                 status;
  } out_item_t;

  // controller -> datapath
  typedef struct packed {
    logic capture;  // latch the incoming item
    logic execute;  // apply the latched item and load the result register
  } ctrl_cmd_t;

endpackage

// ----- rtl/core/iss_ctrl.sv -----
// ----------------------------------------------------------------------------
// iss_ctrl
// Controller: takes one item, waits for the result slot to be free, then has
// the datapath execute it. Owns the input ready and the output valid.
// ----------------------------------------------------------------------------
module iss_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output iss_pkg::ctrl_cmd_t cmd_o
);
  import iss_pkg::*;

  typedef enum logic {
    ST_IDLE,
    ST_EXEC
  } state_e;

  state_e state_q;
  logic   out_valid_q;
  logic   slot_free;

  assign slot_free     = !out_valid_q || out_ready_i;
  assign in_ready_o    = (state_q == ST_IDLE);
  assign out_valid_o   = out_valid_q;
  assign cmd_o.capture = in_valid_i && (state_q == ST_IDLE);
  assign cmd_o.execute = (state_q == ST_EXEC) && slot_free;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      case (state_q)
        ST_IDLE: begin
          if (in_valid_i) begin
            state_q <= ST_EXEC;
          end
          if (out_ready_i) begin
            out_valid_q <= 1'b0;
          end
        end
        ST_EXEC: begin
          if (slot_free) begin
            state_q     <= ST_IDLE;
            out_valid_q <= 1'b1;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  // a result is only produced by an execute
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(cmd_o.execute))
    else $error("output valid raised without execute");

endmodule

// ----- rtl/core/iss_dpath.sv -----
// ----------------------------------------------------------------------------
// iss_dpath
// Datapath: item register, shifting entry array, element count and result
// register. Insert shifts the tail up by one, remove shifts it down by one.
// ----------------------------------------------------------------------------
module iss_dpath (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  iss_pkg::ctrl_cmd_t  cmd_i,
  input  iss_pkg::in_item_t   in_item_i,
  output iss_pkg::out_item_t  out_item_o
);
  import iss_pkg::*;

  in_item_t              item_q;
  out_item_t             result_q, result_d;
  logic [DataWidth-1:0]  entries_q [Depth];
  logic [DataWidth-1:0]  entries_d [Depth];
  logic [DataWidth-1:0]  shift_up  [Depth];
  logic [DataWidth-1:0]  shift_dn  [Depth];
  logic [CountWidth-1:0] count_q, count_d;

  logic [CountWidth-1:0] pos_ext, count_m1, ins_pos, rem_pos;
  logic [IdxWidth-1:0]   rd_idx;
  logic                  full, empty, in_range;
  logic                  do_ins, do_rem, do_rd;

  assign pos_ext  = CountWidth'(item_q.position);
  assign count_m1 = count_q - CountWidth'(1);
  assign full     = (count_q == CountWidth'(Depth));
  assign empty    = (count_q == '0);
  assign in_range = (pos_ext < count_q);

  always_comb begin
    shift_up[0]       = item_q.value;
    shift_dn[Depth-1] = entries_q[Depth-1];
    for (int i = 1; i < Depth; i++) begin
      shift_up[i] = entries_q[i-1];
    end
    for (int i = 0; i < Depth - 1; i++) begin
      shift_dn[i] = entries_q[i+1];
    end
  end

  always_comb begin
    do_ins   = 1'b0;
    do_rem   = 1'b0;
    do_rd    = 1'b0;
    ins_pos  = count_q;
    rem_pos  = pos_ext;
    rd_idx   = item_q.position[IdxWidth-1:0];
    count_d  = count_q;
    result_d.status = STAT_DONE;

    case (item_q.operation)
      OP_PUSH_BACK, OP_PUSH_FRONT, OP_INSERT_AT: begin
        if (item_q.operation == OP_PUSH_FRONT) begin
          ins_pos = '0;
        end else if (item_q.operation == OP_INSERT_AT && in_range) begin
          ins_pos = pos_ext;
        end
        if (full) begin
          result_d.status = STAT_FULL;
        end else begin
          do_ins = 1'b1;
        end
      end
      OP_DELETE_AT: begin
        if (in_range) begin
          do_rem = 1'b1;
        end else begin
          result_d.status = STAT_RANGE;
        end
      end
      OP_READ_AT: begin
        if (in_range) begin
          do_rd = 1'b1;
        end else begin
          result_d.status = STAT_RANGE;
        end
      end
      OP_POP_BACK, OP_POP_FRONT: begin
        if (item_q.operation == OP_POP_BACK) begin
          rem_pos = count_m1;
        end else begin
          rem_pos = '0;
        end
        rd_idx = rem_pos[IdxWidth-1:0];
        if (empty) begin
          result_d.status = STAT_RANGE;
        end else begin
          do_rd  = 1'b1;
          do_rem = 1'b1;
        end
      end
      OP_CLEAR: begin
        count_d = '0;
      end
      default: begin
        count_d = count_q;
      end
    endcase

    if (do_ins) begin
      count_d = count_q + CountWidth'(1);
    end else if (do_rem) begin
      count_d = count_m1;
    end

    for (int i = 0; i < Depth; i++) begin
      entries_d[i] = entries_q[i];
      if (do_ins && CountWidth'(i) >= ins_pos) begin
        entries_d[i] = (CountWidth'(i) == ins_pos) ? item_q.value : shift_up[i];
      end else if (do_rem && CountWidth'(i) >= rem_pos) begin
        entries_d[i] = shift_dn[i];
      end
    end

    result_d.read_value = do_rd ? entries_q[rd_idx] : '0;
    result_d.count      = count_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else if (cmd_i.execute) begin
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      item_q <= in_item_i;
    end
    if (cmd_i.execute) begin
      entries_q <= entries_d;
      result_q  <= result_d;
    end
  end

  assign out_item_o = result_q;

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CountWidth'(Depth))
    else $error("element count above depth");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.execute && item_q.operation == OP_CLEAR |=> count_q == '0)
    else $error("clear left elements");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.execute && item_q.operation == OP_READ_AT |=> $stable(count_q))
    else $error("read changed the element count");

endmodule

// ----- rtl/core/indexed_sequence_store.sv -----
// ----------------------------------------------------------------------------
// indexed_sequence_store
// Bounded ordered sequence (deque) of up to 16 words with push, pop, insert,
// delete, read and clear; one result transfer per input transfer.
// ----------------------------------------------------------------------------
//  channel | signals                          | direction
//  --------+----------------------------------+----------
//  input   | in_valid_i, in_ready_o, in_item_i | in
//  output  | out_valid_o, out_ready_i, out_item_o | out
//
//  An item is latched in the idle state; execute then shifts the entry array
//  and loads the result register. The pace is set by the controller's two
//  states around the single result register.
//  A new item is taken while the previous result still waits; execution
//  holds until the result register is free.
//  Reset clears the element count and the handshake state; entries need none.
// ----------------------------------------------------------------------------
module indexed_sequence_store (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  iss_pkg::in_item_t  in_item_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output iss_pkg::out_item_t out_item_o
);
  import iss_pkg::*;

  ctrl_cmd_t cmd;

  iss_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .cmd_o       (cmd)
  );

  iss_dpath u_dpath (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd),
    .in_item_i  (in_item_i),
    .out_item_o (out_item_o)
  );

endmodule
